@@ sv/swam_pkg.sv @@
// Shared types and constants of the sliding window anagram match unit.
// Used by the front, back and top-level RTL files of the block and by its checker; depends on nothing.
`default_nettype none

package swam_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int MAX_PATTERN_DEF = 256;
   localparam int ALPHABET_DEF    = 26;

   // Fixed field widths of the request and response words.
   localparam int OPCODE_W = 2;
   localparam int LETTER_W = 5;
   localparam int STATUS_W = 2;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PATTERN = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TEXT    = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_AFTER_TEXT = 2'd2;

   // Command queue between the front and back parts, and the response queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_DEPTH   = 2;

   // What the back part has to do with one word.
   typedef enum logic [1:0] {
      KIND_RESTART,
      KIND_NOP,
      KIND_PATTERN,
      KIND_TEXT
   } kind_type;

   // One classified word as it travels from the front part to the back part.
   typedef struct packed {
      kind_type              kind;
      logic [LETTER_W-1:0]   letter;
      logic [LETTER_W-1:0]   old_letter;
      logic [STATUS_W-1:0]   status;
      logic                  touch;    // the histogram has to be updated
      logic                  remove;   // the oldest window letter leaves the window
      logic                  full;     // the window is full after this letter
   } cmd_type;

   // One response word.
   typedef struct packed {
      logic                  window_match;
      logic                  found;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/swam_ram.sv @@
// Generic synchronous RAM: one write port and one or two registered read ports.
// A read at the address being written in the same cycle returns the old data.
`default_nettype none

module swam_ram #(
   parameter int WIDTH    = 8,
   parameter int DEPTH    = 16,
   parameter int RD_PORTS = 1,
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr [RD_PORTS],
   output logic      [WIDTH-1:0] rd_data [RD_PORTS]
);

   logic [WIDTH-1:0] mem_ff     [DEPTH];
   logic [WIDTH-1:0] rd_data_ff [RD_PORTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      for (int i = 0; i < RD_PORTS; i++) begin
         rd_data_ff[i] <= mem_ff[rd_addr[i]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/swam_fifo.sv @@
// Small register-based first-in first-out queue with occupancy count.
// Used for the command queue and the response queue; no package needed.
`default_nettype none

module swam_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full,
   output logic      [CW-1:0]    count
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = data_ff[head_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[tail_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/swam_front.sv @@
// Front part: accepts request words, keeps the pattern length, text count and
// ring pointer, owns the text ring, and classifies each word. Uses swam_pkg, swam_ram.
`default_nettype none

module swam_front #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [swam_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [swam_pkg::LETTER_W-1:0]   req_letter,
   output logic                                 req_full,
   input  wire logic [swam_pkg::QCNT_W-1:0]     q_count,
   output logic                                 q_push,
   output swam_pkg::cmd_type                    q_item
);

   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int QSUM_W = swam_pkg::QCNT_W + 1;

   logic [CNT_W-1:0]  pat_len_ff, pat_len_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              started_ff, started_in;
   logic              f2_valid_ff, f2_valid_in;
   swam_pkg::cmd_type f2_cmd_ff, f2_cmd_in;

   logic              accept;
   logic              letter_ok;
   logic [CNT_W-1:0]  seen_next;
   logic [SUM_W-1:0]  oldest_sum;
   logic [PTR_W-1:0]  oldest_addr;
   logic [PTR_W-1:0]  ptr_next;
   logic              ring_wr_en;
   logic [PTR_W-1:0]  ring_rd_addr [1];
   logic [swam_pkg::LETTER_W-1:0] ring_rd_data [1];

   // Room is counted for the word already in the second stage.
   assign req_full = (QSUM_W'(q_count) + QSUM_W'(f2_valid_ff)) >= QSUM_W'(swam_pkg::QUEUE_DEPTH);
   assign accept    = req_push && !req_full;
   assign letter_ok = int'(req_letter) < ALPHABET;

   assign seen_next  = (seen_ff < CNT_W'(MAX_PATTERN)) ? seen_ff + 1'b1 : seen_ff;
   assign oldest_sum = SUM_W'(ptr_ff) + SUM_W'(MAX_PATTERN) - SUM_W'(pat_len_ff);
   assign oldest_addr = (oldest_sum >= SUM_W'(MAX_PATTERN))
                        ? PTR_W'(oldest_sum - SUM_W'(MAX_PATTERN)) : PTR_W'(oldest_sum);
   assign ptr_next   = (ptr_ff == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr_ff + 1'b1;
   assign ring_rd_addr[0] = oldest_addr;

   always_comb begin
      pat_len_in = pat_len_ff;
      seen_in    = seen_ff;
      ptr_in     = ptr_ff;
      started_in = started_ff;
      ring_wr_en = 1'b0;
      f2_cmd_in            = '0;
      f2_cmd_in.kind       = swam_pkg::KIND_NOP;
      f2_cmd_in.letter     = req_letter;
      f2_cmd_in.status     = swam_pkg::ST_OK;
      if (accept) begin
         unique case (req_opcode)
            swam_pkg::OP_RESTART: begin
               f2_cmd_in.kind = swam_pkg::KIND_RESTART;
               pat_len_in     = '0;
               seen_in        = '0;
               ptr_in         = '0;
               started_in     = 1'b0;
            end
            swam_pkg::OP_PATTERN: begin
               priority if (!letter_ok) begin
                  f2_cmd_in.kind = swam_pkg::KIND_NOP;
               end else if (started_ff) begin
                  f2_cmd_in.status = swam_pkg::ST_AFTER_TEXT;
               end else if (pat_len_ff == CNT_W'(MAX_PATTERN)) begin
                  f2_cmd_in.status = swam_pkg::ST_TOO_LONG;
               end else begin
                  f2_cmd_in.kind = swam_pkg::KIND_PATTERN;
                  pat_len_in     = pat_len_ff + 1'b1;
               end
            end
            swam_pkg::OP_TEXT: begin
               if (letter_ok) begin
                  f2_cmd_in.kind   = swam_pkg::KIND_TEXT;
                  f2_cmd_in.touch  = (pat_len_ff != '0);
                  f2_cmd_in.remove = (pat_len_ff != '0) && (seen_ff >= pat_len_ff);
                  f2_cmd_in.full   = (seen_next >= pat_len_ff);
                  ring_wr_en       = 1'b1;
                  seen_in          = seen_next;
                  ptr_in           = ptr_next;
                  started_in       = 1'b1;
               end
            end
            default: begin
               f2_cmd_in.kind = swam_pkg::KIND_NOP;
            end
         endcase
      end
      f2_valid_in = accept;
   end

   // The oldest letter read in the accept cycle is attached in the following cycle.
   always_comb begin
      q_item            = f2_cmd_ff;
      q_item.old_letter = ring_rd_data[0];
   end
   assign q_push = f2_valid_ff;

   swam_ram #(
      .WIDTH    (swam_pkg::LETTER_W),
      .DEPTH    (MAX_PATTERN),
      .RD_PORTS (1)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (req_letter),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         seen_ff     <= '0;
         ptr_ff      <= '0;
         started_ff  <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         pat_len_ff  <= pat_len_in;
         seen_ff     <= seen_in;
         ptr_ff      <= ptr_in;
         started_ff  <= started_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f2_cmd_ff <= f2_cmd_in;
   end

endmodule

`default_nettype wire

@@ sv/swam_back.sv @@
// Back part: executes classified words against the letter histogram RAM,
// keeps the mismatch count and found flag, and forms responses. Uses swam_pkg, swam_ram.
`default_nettype none

module swam_back #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire swam_pkg::cmd_type q_item,
   output logic                   q_pop,
   input  wire logic              o_full,
   output logic                   o_push,
   output swam_pkg::rsp_type      o_item
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int MW    = $clog2(ALPHABET + 1);

   typedef struct packed {
      logic [CNT_W-1:0] pat;
      logic [CNT_W-1:0] win;
   } entry_type;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type         state_ff, state_in;
   swam_pkg::cmd_type cmd_ff, cmd_in;
   logic [ALPHABET-1:0] valid_ff, valid_in;
   logic              vld_a_ff, vld_a_in, vld_b_ff, vld_b_in;
   logic              fwd_a_ff, fwd_a_in, fwd_b_ff, fwd_b_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   entry_type         pend_data_ff, pend_data_in;
   logic [MW-1:0]     mism_ff, mism_in;
   logic              found_ff, found_in;

   logic [AW-1:0]     head_a, head_b, cur_a, cur_b;
   logic [AW-1:0]     rd_addr [2];
   logic [2*CNT_W-1:0] rd_data [2];
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;

   entry_type         ent_a, ent_b, new_a, base_b, new_b;
   logic              rem, same, start, idle_match, upd_match;
   logic [MW-1:0]     m1, m2;

   // Keeps the count of letters whose pattern and window counts differ.
   function automatic logic [MW-1:0] step_mism(input logic [MW-1:0] m,
                                               input logic before_ne,
                                               input logic after_ne);
      logic [MW-1:0] res;
      res = m;
      if (before_ne && !after_ne && (m != '0)) begin
         res = m - 1'b1;
      end else if (!before_ne && after_ne) begin
         res = m + 1'b1;
      end
      return res;
   endfunction

   assign head_a = AW'(q_item.old_letter);
   assign head_b = AW'(q_item.letter);
   assign cur_a  = AW'(cmd_ff.old_letter);
   assign cur_b  = AW'(cmd_ff.letter);
   assign rd_addr[0] = head_a;
   assign rd_addr[1] = head_b;

   // An entry never written since restart reads as zero; a pending write wins.
   assign ent_a = fwd_a_ff ? pend_data_ff : (vld_a_ff ? entry_type'(rd_data[0]) : '0);
   assign ent_b = fwd_b_ff ? pend_data_ff : (vld_b_ff ? entry_type'(rd_data[1]) : '0);

   always_comb begin
      rem  = cmd_ff.remove && (int'(cmd_ff.old_letter) < ALPHABET);
      same = rem && (cur_a == cur_b);
      new_a = ent_a;
      if (rem && (ent_a.win != '0)) begin
         new_a.win = ent_a.win - 1'b1;
      end
      m1 = rem ? step_mism(mism_ff, ent_a.pat != ent_a.win, new_a.pat != new_a.win) : mism_ff;
      base_b = same ? new_a : ent_b;
      new_b  = base_b;
      if (cmd_ff.kind == swam_pkg::KIND_PATTERN) begin
         new_b.pat = base_b.pat + 1'b1;
      end else begin
         new_b.win = base_b.win + 1'b1;
      end
      m2 = step_mism(m1, base_b.pat != base_b.win, new_b.pat != new_b.win);
      upd_match = (cmd_ff.kind == swam_pkg::KIND_TEXT) && cmd_ff.full && (m2 == '0);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      mism_in       = mism_ff;
      found_in      = found_ff;
      vld_a_in      = (int'(head_a) < ALPHABET) ? valid_ff[head_a] : 1'b0;
      vld_b_in      = (int'(head_b) < ALPHABET) ? valid_ff[head_b] : 1'b0;
      fwd_a_in      = pend_valid_ff && (pend_addr_ff == head_a);
      fwd_b_in      = pend_valid_ff && (pend_addr_ff == head_b);
      q_pop         = 1'b0;
      o_push        = 1'b0;
      o_item.window_match = 1'b0;
      o_item.found        = found_ff;
      o_item.status       = swam_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = pend_data_ff;
      start         = !q_empty && !o_full;
      idle_match    = q_item.full && (mism_ff == '0);
      unique case (state_ff)
         S_IDLE: begin
            // The second write of the previous text letter lands here.
            pend_valid_in = 1'b0;
            if (pend_valid_ff && !(start && (q_item.kind == swam_pkg::KIND_RESTART))) begin
               wr_en                  = 1'b1;
               valid_in[pend_addr_ff] = 1'b1;
            end
            if (start) begin
               q_pop  = 1'b1;
               cmd_in = q_item;
               unique case (q_item.kind)
                  swam_pkg::KIND_RESTART: begin
                     valid_in     = '0;
                     mism_in      = '0;
                     found_in     = 1'b0;
                     o_push       = 1'b1;
                     o_item.found = 1'b0;
                  end
                  swam_pkg::KIND_NOP: begin
                     o_push        = 1'b1;
                     o_item.status = q_item.status;
                  end
                  swam_pkg::KIND_PATTERN: begin
                     state_in = S_UPDATE;
                  end
                  swam_pkg::KIND_TEXT: begin
                     if (q_item.touch) begin
                        state_in = S_UPDATE;
                     end else begin
                        found_in            = found_ff | idle_match;
                        o_push              = 1'b1;
                        o_item.window_match = idle_match;
                        o_item.found        = found_ff | idle_match;
                     end
                  end
               endcase
            end
         end
         S_UPDATE: begin
            wr_en = 1'b1;
            if (rem && !same) begin
               wr_addr         = cur_a;
               wr_data         = new_a;
               valid_in[cur_a] = 1'b1;
               pend_valid_in   = 1'b1;
               pend_addr_in    = cur_b;
               pend_data_in    = new_b;
            end else begin
               wr_addr         = cur_b;
               wr_data         = new_b;
               valid_in[cur_b] = 1'b1;
            end
            mism_in             = m2;
            found_in            = found_ff | upd_match;
            o_push              = 1'b1;
            o_item.window_match = upd_match;
            o_item.found        = found_ff | upd_match;
            state_in            = S_IDLE;
         end
      endcase
   end

   swam_ram #(
      .WIDTH    (2 * CNT_W),
      .DEPTH    (ALPHABET),
      .RD_PORTS (2)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      vld_a_ff     <= vld_a_in;
      vld_b_ff     <= vld_b_in;
      fwd_a_ff     <= fwd_a_in;
      fwd_b_ff     <= fwd_b_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         mism_ff       <= '0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         mism_ff       <= mism_in;
         found_ff      <= found_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/sliding_window_anagram_match_unit.sv @@
// Top level of the sliding window anagram match unit.
// Instantiates swam_front, swam_back and two swam_fifo queues; uses swam_pkg.
`default_nettype none

// The unit takes a pattern and then a text as a stream of request words, each
// an opcode (restart, pattern letter, text letter) and a letter index, and
// answers every word with one response word: window_match is set when the
// last pattern-length text letters are a permutation of the pattern, found is
// the sticky or of all matches since the last restart, and status flags a
// pattern letter dropped for length or rejected because text has begun. Both
// sides behave as queues: a word is taken when req_push is high and req_full
// low, and the oldest response is offered while rsp_empty is low and leaves
// when rsp_pop is high. A pattern letter, or a text letter with a non-empty
// pattern, takes the back part through S_IDLE, which reads the histogram
// entries it touches (for text, the letter entering and the letter leaving
// the window), and S_UPDATE, which writes them back. The histogram RAM has a
// single write port, so when two different entries change, the second write
// lands in the following cycle while the back part already starts the next
// word. Every other word is handled in S_IDLE alone. The front part takes one
// word per cycle while req_full is low into a four-word command queue, so a
// burst is absorbed while the back part works. A response passes through the
// front's second stage, the command queue, the back part and the response
// queue, and may wait in the command queue or for room in the response queue.
// Restart needs no clearing pass: valid bits on the histogram entries are
// cleared at once, and the text ring is only ever read where it was written.
module sliding_window_anagram_match_unit #(
   parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = swam_pkg::ALPHABET_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [swam_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [swam_pkg::LETTER_W-1:0]   req_letter,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_window_match,
   output logic                                 rsp_found,
   output logic [swam_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int CMD_W = $bits(swam_pkg::cmd_type);
   localparam int RSP_W = $bits(swam_pkg::rsp_type);
   localparam int RCNT_W = $clog2(swam_pkg::RSP_DEPTH + 1);

   // Front to command queue.
   logic                       f_push;
   swam_pkg::cmd_type          f_item;
   logic [swam_pkg::QCNT_W-1:0] q_count;
   // The front counts room itself, so the full flag of this queue is not needed.
   logic                       unused_q_full;

   // Command queue to back.
   logic [CMD_W-1:0]           q_data;
   swam_pkg::cmd_type          q_item;
   logic                       q_empty;
   logic                       q_pop;

   // Back to response queue.
   logic                       o_push;
   swam_pkg::rsp_type          o_item;
   logic                       o_full;
   logic [RSP_W-1:0]           r_data;
   swam_pkg::rsp_type          r_item;
   logic [RCNT_W-1:0]          r_count;

   swam_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_opcode (req_opcode),
      .req_letter (req_letter),
      .req_full   (req_full),
      .q_count    (q_count),
      .q_push     (f_push),
      .q_item     (f_item)
   );

   // The front reserves room before accepting, so the queue never refuses.
   swam_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (swam_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_item),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (unused_q_full),
      .count     (q_count)
   );

   assign q_item = swam_pkg::cmd_type'(q_data);

   swam_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .o_full  (o_full),
      .o_push  (o_push),
      .o_item  (o_item)
   );

   // The back starts a word only when this queue has room for its response.
   swam_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (swam_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_item),
      .pop       (rsp_pop),
      .pop_data  (r_data),
      .empty     (rsp_empty),
      .full      (o_full),
      .count     (r_count)
   );

   assign r_item           = swam_pkg::rsp_type'(r_data);
   assign rsp_window_match = r_item.window_match && (r_count != '0);
   assign rsp_found        = r_item.found;
   assign rsp_status       = r_item.status;

endmodule

`default_nettype wire

@@ sv/swam_checker.sv @@
// Port-level checker for the sliding window anagram match unit, bound to its top level.
// Uses swam_pkg for the status codes.
`default_nettype none

module swam_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_push,
   input wire logic                          req_full,
   input wire logic [swam_pkg::OPCODE_W-1:0] req_opcode,
   input wire logic [swam_pkg::LETTER_W-1:0] req_letter,
   input wire logic                          rsp_empty,
   input wire logic                          rsp_pop,
   input wire logic                          rsp_window_match,
   input wire logic                          rsp_found,
   input wire logic [swam_pkg::STATUS_W-1:0] rsp_status
);

   // Reset leaves both queues empty and the request side open.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty or request side blocked after reset");

   // A matching window always shows in the sticky flag of the same word.
   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_window_match) |-> rsp_found)
      else $error("window match without found");

   // Only accepted text letters can match, and those carry an ok status.
   a_match_status_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_window_match) |-> (rsp_status == swam_pkg::ST_OK))
      else $error("window match with a non-ok status");

   // A waiting response that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_window_match) && $stable(rsp_found)
          && $stable(rsp_status)))
      else $error("waiting response changed or vanished");

   // Request ports are observed only through the bind.
   logic unused_req;
   assign unused_req = req_push ^ (^req_opcode) ^ (^req_letter);

endmodule

bind sliding_window_anagram_match_unit swam_checker u_checker (.*);

`default_nettype wire

@@ tb/sliding_window_anagram_match_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the sliding window anagram match unit.
// Depends on swam_pkg and sliding_window_anagram_match_unit only.

module sliding_window_anagram_match_unit_tb;

   import swam_pkg::*;

   // Sizes of the instance under test; the predictor uses the same values.
   localparam int MAX_PATTERN = MAX_PATTERN_DEF;
   localparam int ALPHABET    = ALPHABET_DEF;

   // Opcode 3 has no name in the package because the unit ignores it.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Cycles to wait after the last owed response so that a stray one shows up.
   localparam int DRAIN_CYCLES = 16;

   // One request word waiting to be offered. When hold_off is set, the driver
   // keeps it back until every response of the words before it has arrived.
   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [LETTER_W-1:0] letter;
      bit                  hold_off;
   } pending_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [OPCODE_W-1:0] req_opcode = OP_RESTART;
   logic [LETTER_W-1:0] req_letter = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_window_match;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;

   // Words still to be offered, and responses still owed by the unit.
   pending_word_type pending_words[$];
   rsp_type          owed_verdicts[$];

   // Idle percentages of the two sides, changed by the stimulus between phases.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Counters for the summary and the verdict.
   int live_words_queued = 0;
   int words_sent        = 0;
   int verdicts_checked  = 0;
   int matches_seen      = 0;
   int mismatches        = 0;

   // Predictor state: the two letter histograms, the ring of recent text
   // letters, and the bookkeeping that decides when the window is full.
   logic [8:0] pat_count[ALPHABET];
   logic [8:0] win_count[ALPHABET];
   logic [LETTER_W-1:0] recent_text[MAX_PATTERN];
   logic [7:0] wr_ptr;
   logic [8:0] pat_len;
   logic [8:0] text_len;
   logic [4:0] differ_letters;
   logic       found_seen;
   logic       text_begun;

   sliding_window_anagram_match_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_letter       (req_letter),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_window_match (rsp_window_match),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   // Returns the predictor to its power-up state; a restart word does the same.
   function automatic void clear_predictor();
      for (int i = 0; i < ALPHABET; i++) begin
         pat_count[i] = '0;
         win_count[i] = '0;
      end
      // The ring is never read where it was not written; zero keeps it clean.
      for (int i = 0; i < MAX_PATTERN; i++) begin
         recent_text[i] = '0;
      end
      wr_ptr         = '0;
      pat_len        = '0;
      text_len       = '0;
      differ_letters = '0;
      found_seen     = 1'b0;
      text_begun     = 1'b0;
   endfunction

   // Moves one histogram count up or down and keeps the number of letters
   // whose pattern and window counts differ exact.
   function automatic void bump_count(input bit in_window, input logic [LETTER_W-1:0] idx,
                                      input bit up);
      bit differs_then;
      bit differs_now;
      differs_then = (pat_count[idx] != win_count[idx]);
      if (in_window) begin
         if (up) begin
            win_count[idx] = win_count[idx] + 1'b1;
         end else if (win_count[idx] != 0) begin
            win_count[idx] = win_count[idx] - 1'b1;
         end
      end else begin
         if (up) begin
            pat_count[idx] = pat_count[idx] + 1'b1;
         end else if (pat_count[idx] != 0) begin
            pat_count[idx] = pat_count[idx] - 1'b1;
         end
      end
      differs_now = (pat_count[idx] != win_count[idx]);
      if (differs_then && !differs_now && differ_letters != 0) begin
         differ_letters = differ_letters - 1'b1;
      end else if (!differs_then && differs_now) begin
         differ_letters = differ_letters + 1'b1;
      end
   endfunction

   // Applies one accepted word to the predictor and returns the response
   // that the unit has to give for it.
   function automatic rsp_type anagram_step(input logic [OPCODE_W-1:0] opcode,
                                            input logic [LETTER_W-1:0] letter);
      rsp_type    verdict;
      logic [7:0] oldest;
      verdict        = '0;
      verdict.status = ST_OK;
      case (opcode)
         OP_RESTART: begin
            clear_predictor();
         end
         OP_PATTERN: begin
            if (letter < ALPHABET) begin
               if (text_begun) begin
                  verdict.status = ST_AFTER_TEXT;
               end else if (pat_len >= MAX_PATTERN) begin
                  verdict.status = ST_TOO_LONG;
               end else begin
                  bump_count(1'b0, letter, 1'b1);
                  pat_len = pat_len + 1'b1;
               end
            end
         end
         OP_TEXT: begin
            if (letter < ALPHABET) begin
               text_begun = 1'b1;
               if (pat_len != 0) begin
                  // Once the window is full, the letter pat_len places back leaves it.
                  if (text_len >= pat_len) begin
                     oldest = wr_ptr - pat_len[7:0];
                     bump_count(1'b1, recent_text[oldest], 1'b0);
                  end
                  bump_count(1'b1, letter, 1'b1);
               end
               recent_text[wr_ptr] = letter;
               wr_ptr = wr_ptr + 1'b1;
               if (text_len < MAX_PATTERN) begin
                  text_len = text_len + 1'b1;
               end
               if (text_len >= pat_len && differ_letters == 0) begin
                  verdict.window_match = 1'b1;
                  found_seen           = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      verdict.found = found_seen;
      return verdict;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Queues one word. Words that the unit merely ignores do not count toward
   // the size of a phase.
   task automatic queue_word(input logic [OPCODE_W-1:0] opcode,
                             input logic [LETTER_W-1:0] letter, input bit hold_off);
      pending_word_type w;
      w.opcode   = opcode;
      w.letter   = letter;
      w.hold_off = hold_off;
      pending_words.push_back(w);
      if (opcode == OP_RESTART || (opcode != OP_UNUSED && letter < ALPHABET)) begin
         live_words_queued++;
      end
   endtask

   function automatic void shuffle_letters(ref logic [LETTER_W-1:0] q[$]);
      int j;
      logic [LETTER_W-1:0] tmp;
      for (int i = q.size() - 1; i > 0; i--) begin
         j    = $urandom_range(i, 0);
         tmp  = q[i];
         q[i] = q[j];
         q[j] = tmp;
      end
   endfunction

   // Now and then throws in a word that the unit has to ignore: the unused
   // opcode, or a pattern or text letter outside the alphabet.
   task automatic maybe_queue_noise();
      if ($urandom_range(11, 0) == 0) begin
         case ($urandom_range(2, 0))
            0: queue_word(OP_UNUSED, LETTER_W'($urandom_range(31, 0)), 1'b0);
            1: queue_word(OP_PATTERN, LETTER_W'($urandom_range(31, ALPHABET)), 1'b0);
            default: queue_word(OP_TEXT, LETTER_W'($urandom_range(31, ALPHABET)), 1'b0);
         endcase
      end
   endtask

   // One well-formed run with random content: a restart (now and then skipped), a short pattern, and
   // a text that mostly cycles through a shuffled copy of the pattern, so that
   // full windows are permutations of it unless a stray letter breaks them.
   task automatic queue_anagram_run(input bit hold_off);
      logic [LETTER_W-1:0] pat[$];
      logic [LETTER_W-1:0] l;
      int plen;
      int pick;
      int body;
      pick = $urandom_range(9, 0);
      // A run now and then skips its restart, so it carries on from the last one.
      if (hold_off || pick != 9) begin
         queue_word(OP_RESTART, LETTER_W'($urandom_range(31, 0)),
                    hold_off || ($urandom_range(29, 0) == 0));
      end
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         plen = 0;
      end else if (pick < 8) begin
         plen = $urandom_range(6, 1);
      end else begin
         plen = $urandom_range(20, 7);
      end
      for (int i = 0; i < plen; i++) begin
         l = LETTER_W'($urandom_range(ALPHABET - 1, 0));
         pat.push_back(l);
         queue_word(OP_PATTERN, l, 1'b0);
         maybe_queue_noise();
      end
      shuffle_letters(pat);
      // A few random text letters ahead of the cyclic part.
      for (int i = $urandom_range(3, 0); i > 0; i--) begin
         queue_word(OP_TEXT, LETTER_W'($urandom_range(ALPHABET - 1, 0)), 1'b0);
      end
      body = $urandom_range(3 * plen + 4, 0);
      for (int i = 0; i < body; i++) begin
         if (plen == 0 || $urandom_range(7, 0) == 0) begin
            queue_word(OP_TEXT, LETTER_W'($urandom_range(ALPHABET - 1, 0)), 1'b0);
         end else begin
            queue_word(OP_TEXT, pat[i % plen], 1'b0);
         end
         maybe_queue_noise();
         // A pattern letter once text has begun must be rejected.
         if ($urandom_range(24, 0) == 0) begin
            queue_word(OP_PATTERN, LETTER_W'($urandom_range(ALPHABET - 1, 0)), 1'b0);
         end
      end
   endtask

   // The longest pattern the unit holds, two letters too many to see them
   // dropped, and a text long enough for the letter count to saturate.
   task automatic queue_long_pattern_run();
      logic [LETTER_W-1:0] pat[$];
      logic [LETTER_W-1:0] l;
      queue_word(OP_RESTART, '0, 1'b0);
      for (int i = 0; i < MAX_PATTERN + 2; i++) begin
         l = LETTER_W'($urandom_range(ALPHABET - 1, 0));
         if (i < MAX_PATTERN) begin
            pat.push_back(l);
         end
         queue_word(OP_PATTERN, l, 1'b0);
      end
      shuffle_letters(pat);
      for (int i = 0; i < MAX_PATTERN + 14; i++) begin
         queue_word(OP_TEXT, pat[i % MAX_PATTERN], 1'b0);
      end
      queue_word(OP_PATTERN, 5'd7, 1'b0);
      queue_word(OP_TEXT, LETTER_W'($urandom_range(ALPHABET - 1, 0)), 1'b0);
   endtask

   // Driver. Everything changes at the falling edge, away from the rising edge
   // where the unit samples. A word stays on offer until it is taken; the
   // sender may withdraw it before it is taken, which the queue allows.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (pending_words.size() != 0
             && !(pending_words[0].hold_off && owed_verdicts.size() != 0)
             && $urandom_range(99, 0) >= send_idle_pct) begin
            req_push   <= 1'b1;
            req_opcode <= pending_words[0].opcode;
            req_letter <= pending_words[0].letter;
         end else begin
            // The payload wanders while no word is offered; it must not matter.
            req_push   <= 1'b0;
            req_opcode <= OPCODE_W'($urandom_range(3, 0));
            req_letter <= LETTER_W'($urandom_range(31, 0));
         end
         rsp_pop <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Monitor. Both handshakes are sampled at the rising edge. The response
   // side is looked at first, so a word taken at the same edge can never be
   // mistaken for the owner of a response leaving at that edge.
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got.window_match = rsp_window_match;
            got.found        = rsp_found;
            got.status       = rsp_status;
            if (owed_verdicts.size() == 0) begin
               report_mismatch($sformatf("response %0b/%0b/%0d with nothing outstanding",
                                         got.window_match, got.found, got.status));
            end else begin
               want = owed_verdicts.pop_front();
               verdicts_checked++;
               if (want.window_match) begin
                  matches_seen++;
               end
               if (got.window_match !== want.window_match) begin
                  report_mismatch($sformatf("response %0d: window_match %b, expected %b",
                                            verdicts_checked, got.window_match,
                                            want.window_match));
               end
               if (got.found !== want.found) begin
                  report_mismatch($sformatf("response %0d: found %b, expected %b",
                                            verdicts_checked, got.found, want.found));
               end
               if (got.status !== want.status) begin
                  report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                            verdicts_checked, got.status, want.status));
               end
            end
         end
         if (req_push && !req_full) begin
            owed_verdicts.push_back(anagram_step(req_opcode, req_letter));
            pending_words.delete(0);
            words_sent++;
         end
      end
   end

   // Stimulus. A directed opening, then four phases of random runs, each
   // with its own idling, each drained before the next one starts.
   initial begin : stimulus
      int target;
      clear_predictor();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pattern: every text letter matches and found goes up.
      queue_word(OP_RESTART, 5'd31, 1'b0);
      queue_word(OP_TEXT, 5'd0, 1'b0);
      queue_word(OP_TEXT, 5'd25, 1'b0);
      queue_word(OP_PATTERN, 5'd3, 1'b0);
      queue_word(OP_UNUSED, 5'd31, 1'b0);
      // A two-letter pattern with letters out of range mixed in.
      queue_word(OP_RESTART, 5'd0, 1'b0);
      queue_word(OP_PATTERN, 5'd0, 1'b0);
      queue_word(OP_PATTERN, 5'd25, 1'b0);
      queue_word(OP_PATTERN, 5'd26, 1'b0);
      queue_word(OP_PATTERN, 5'd31, 1'b0);
      queue_word(OP_TEXT, 5'd25, 1'b0);
      queue_word(OP_TEXT, 5'd31, 1'b0);
      queue_word(OP_TEXT, 5'd0, 1'b0);
      queue_word(OP_TEXT, 5'd0, 1'b0);
      queue_word(OP_TEXT, 5'd25, 1'b0);
      queue_word(OP_UNUSED, 5'd0, 1'b0);
      queue_word(OP_TEXT, 5'd26, 1'b0);
      queue_word(OP_PATTERN, 5'd1, 1'b0);
      // Restart clears found; then a one-letter pattern with alternating bits.
      queue_word(OP_RESTART, 5'd21, 1'b0);
      queue_word(OP_PATTERN, 5'd10, 1'b0);
      queue_word(OP_TEXT, 5'd21, 1'b0);
      queue_word(OP_TEXT, 5'd10, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            1: begin
               send_idle_pct = 77;
               recv_idle_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_idle_pct = 77;
            end
            default: begin
               send_idle_pct = 37;
               recv_idle_pct = 37;
            end
         endcase
         target = live_words_queued + 110;
         if (phase == 0) begin
            queue_long_pattern_run();
         end
         // The first run of the second phase waits for the unit to drain.
         queue_anagram_run(phase == 1);
         while (live_words_queued < target) begin
            queue_anagram_run(1'b0);
         end
         while (pending_words.size() != 0 || owed_verdicts.size() != 0) begin
            @(posedge clock);
         end
      end

      // Nothing is owed any more; give a stray response time to show up.
      recv_idle_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d words sent, %0d responses checked, %0d of them window matches,",
               words_sent, verdicts_checked, matches_seen);
      $display("over four idling phases and a full-length pattern; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: a correct run ends far earlier than this.
   initial begin
      #5_000_000;
      $display("timeout with %0d words waiting and %0d responses owed",
               pending_words.size(), owed_verdicts.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/swam_pkg.sv
sv/swam_ram.sv
sv/swam_fifo.sv
sv/swam_front.sv
sv/swam_back.sv
sv/sliding_window_anagram_match_unit.sv
sv/swam_checker.sv
tb/sliding_window_anagram_match_unit_tb.sv
